// ===== rtl/aac_adts_sync_finder_top_defines.svh =====
// Assertion macros shared by the RTL of the ADTS sync finder.
`ifndef AAC_ADTS_SYNC_FINDER_TOP_DEFINES_SVH
`define AAC_ADTS_SYNC_FINDER_TOP_DEFINES_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define AACSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define AACSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aacsf_pkg.sv =====
package aacsf_pkg;

  localparam int unsigned OFFSET_WIDTH = 16;
  localparam int unsigned OFFSET_OUT_W = 16;
  localparam int unsigned WIN_LEN      = 10;
  localparam int unsigned FILL_W       = 4;
  localparam int unsigned TAIL_CANDS   = 3;
  localparam int unsigned RATE_W       = 17;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned FL_W         = 13;
  localparam int unsigned HB_W         = 4;
  localparam int unsigned HDR_TOP      = 8 * WIN_LEN - 1;

  localparam logic [11:0]       ADTS_SYNC   = 12'hFFF;
  localparam logic [1:0]        LAYER_ADTS  = 2'd0;
  localparam logic [HB_W-1:0]   HB_ID0      = 4'd8;
  localparam logic [HB_W-1:0]   HB_ID1      = 4'd7;
  localparam logic [HB_W-1:0]   HB_CRC      = 4'd2;
  localparam logic [CH_W-1:0]   CH_MAX      = 3'd6;
  localparam logic [CH_W-1:0]   CH_FALLBACK = 3'd2;
  localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(WIN_LEN);
  localparam logic [FILL_W-1:0] FILL_SHIFT  = FILL_W'(WIN_LEN - 1);
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

  typedef logic [WIN_LEN-1:0][7:0] window_t;
  typedef logic [8*WIN_LEN-1:0]    hdr_bits_t;

  typedef struct packed {
    logic              sync_ok;
    logic              mpeg_id;
    logic [1:0]        profile;
    logic [RATE_W-1:0] samp_freq;
    logic [CH_W-1:0]   channels;
    logic [FL_W-1:0]   frame_len;
    logic              crc_present;
    logic [HB_W-1:0]   header_bytes;
  } hdr_t;

  typedef struct packed {
    logic                    found;
    logic [OFFSET_OUT_W-1:0] offset;
    logic                    mpeg_id;
    logic [1:0]              profile;
    logic [RATE_W-1:0]       samp_freq;
    logic [CH_W-1:0]         channels;
    logic [FL_W-1:0]         frame_len;
    logic                    crc_present;
    logic [HB_W-1:0]         header_bytes;
  } res_t;

  function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
    logic [RATE_W-1:0] r;
    unique case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // The header starts at the most significant bit of h.
  function automatic hdr_t hdr_decode(input hdr_bits_t h);
    hdr_t            r;
    logic [CH_W-1:0] ch;
    logic            prot_absent;
    r.sync_ok      = (h[HDR_TOP -: 12] == ADTS_SYNC) && (h[HDR_TOP-13 -: 2] == LAYER_ADTS);
    r.mpeg_id      = h[HDR_TOP-12];
    prot_absent    = h[HDR_TOP-15];
    r.profile      = h[HDR_TOP-16 -: 2];
    r.samp_freq    = rate_lookup(h[HDR_TOP-18 -: 4]);
    ch             = h[HDR_TOP-23 -: 3];
    r.channels     = (ch > CH_MAX) ? CH_FALLBACK : ch;
    r.frame_len    = r.mpeg_id ? h[HDR_TOP-30 -: FL_W] : h[HDR_TOP-32 -: FL_W];
    r.crc_present  = !prot_absent;
    r.header_bytes = (r.mpeg_id ? HB_ID1 : HB_ID0) + (prot_absent ? '0 : HB_CRC);
    return r;
  endfunction

  function automatic logic [OFFSET_WIDTH-1:0] sat_add(input logic [OFFSET_WIDTH-1:0] a,
                                                      input logic [1:0] b);
    logic [OFFSET_WIDTH+1:0] s;
    s = {2'b00, a} + {{OFFSET_WIDTH{1'b0}}, b};
    return (s >= {2'b00, OFFSET_MAX}) ? OFFSET_MAX : s[OFFSET_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/aacsf_if.sv =====
interface aacsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aacsf_out_if import aacsf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [OFFSET_OUT_W-1:0] offset;
  logic                    mpeg_id;
  logic [1:0]              profile;
  logic [RATE_W-1:0]       samp_freq;
  logic [CH_W-1:0]         channels;
  logic [FL_W-1:0]         frame_len;
  logic                    crc_present;
  logic [HB_W-1:0]         header_bytes;

  modport source (
    output valid, output found, output offset, output mpeg_id, output profile,
    output samp_freq, output channels, output frame_len, output crc_present,
    output header_bytes, input ready
  );
  modport sink (
    input valid, input found, input offset, input mpeg_id, input profile,
    input samp_freq, input channels, input frame_len, input crc_present,
    input header_bytes, output ready
  );
endinterface

// ===== rtl/aac_adts_sync_finder_top.sv =====
// Finds the first ADTS header in a buffer that arrives one byte per beat on in_i.
// The final byte of a buffer carries last_byte. Each buffer yields exactly one beat
// on out_o: the offset and decoded fields of the first header, or found low with
// all other fields zero when the buffer ends without a complete header.
// A header is reported once its ten-byte window has filled, which is the beat
// that carries the tenth byte from the header start, or on the last byte for a
// header near the buffer end. Later bytes of that buffer are consumed silently.
// The result appears on out_o in the cycle after the deciding beat is accepted.
// Throughput is one byte per cycle while out_o takes results: the window update
// and all header decoders sit between the window registers and the result register.
// When out_o stalls with a result held, in_i stops taking bytes until that
// result leaves; a result register alone parts the two sides.
// Reset clears the window, its fill count, the offset counter and the result valid flag.
`include "aac_adts_sync_finder_top_defines.svh"

module aac_adts_sync_finder_top import aacsf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  aacsf_in_if.sink     in_i,
  aacsf_out_if.source  out_o
);

  window_t                 win_q, win_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic                    rep_q, rep_d;
  logic                    out_valid_q, out_valid_d;
  res_t                    res_q, res_d;

  logic                    in_fire;
  logic                    emit;
  window_t                 w_new, w_shift, tail_win;
  logic [FILL_W-1:0]       fill_new, tail_fill;
  logic [OFFSET_WIDTH-1:0] tail_pos;
  logic                    full;
  hdr_bits_t               head_bits;
  hdr_t                    head;
  hdr_bits_t               cand_bits [TAIL_CANDS];
  hdr_t                    cand      [TAIL_CANDS];
  logic [TAIL_CANDS-1:0]   cand_ok;
  hdr_t                    sel_hdr;
  logic                    sel_found;
  logic [OFFSET_WIDTH-1:0] sel_off;
  logic [OFFSET_WIDTH+OFFSET_OUT_W-1:0] off_ext;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    for (int k = 0; k < WIN_LEN; k++) begin
      w_new[k] = (FILL_W'(k) == fill_q) ? in_i.data_byte : win_q[k];
    end
    fill_new = fill_q + FILL_W'(1);
    full     = (fill_new == FILL_FULL);
    for (int k = 0; k < WIN_LEN; k++) begin
      head_bits[8*(WIN_LEN-k)-1 -: 8] = w_new[k];
      w_shift[k] = (k < WIN_LEN - 1) ? w_new[(k+1) % WIN_LEN] : 8'd0;
    end
    head      = hdr_decode(head_bits);
    tail_win  = full ? w_shift : w_new;
    tail_fill = full ? FILL_SHIFT : fill_new;
    tail_pos  = full ? sat_add(pos_q, 2'd1) : pos_q;
  end

  always_comb begin
    for (int c = 0; c < TAIL_CANDS; c++) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        cand_bits[c][8*(WIN_LEN-k)-1 -: 8] =
          (k + c < WIN_LEN) ? tail_win[(k+c) % WIN_LEN] : 8'd0;
      end
      cand[c]    = hdr_decode(cand_bits[c]);
      cand_ok[c] = cand[c].sync_ok &&
                   ((5'(cand[c].header_bytes) + 5'(c)) <= 5'(tail_fill));
    end
    sel_found = 1'b0;
    sel_hdr   = '0;
    sel_off   = '0;
    for (int c = TAIL_CANDS - 1; c >= 0; c--) begin
      if (cand_ok[c]) begin
        sel_found = 1'b1;
        sel_hdr   = cand[c];
        sel_off   = sat_add(tail_pos, 2'(c));
      end
    end
  end

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    rep_d   = rep_q;
    emit    = 1'b0;
    res_d   = res_q;
    off_ext = '0;
    if (in_fire) begin
      if (rep_q) begin
        if (in_i.last_byte) begin
          win_d  = '0;
          fill_d = '0;
          pos_d  = '0;
          rep_d  = 1'b0;
        end
      end else if (full && head.sync_ok) begin
        emit    = 1'b1;
        off_ext = {{OFFSET_OUT_W{1'b0}}, pos_q};
        res_d   = '{found: 1'b1, offset: off_ext[OFFSET_OUT_W-1:0], mpeg_id: head.mpeg_id,
                    profile: head.profile, samp_freq: head.samp_freq,
                    channels: head.channels, frame_len: head.frame_len,
                    crc_present: head.crc_present, header_bytes: head.header_bytes};
        if (in_i.last_byte) begin
          win_d  = '0;
          fill_d = '0;
          pos_d  = '0;
        end else begin
          win_d  = w_new;
          fill_d = fill_new;
          rep_d  = 1'b1;
        end
      end else begin
        win_d  = tail_win;
        fill_d = tail_fill;
        pos_d  = tail_pos;
        if (in_i.last_byte) begin
          emit    = 1'b1;
          off_ext = {{OFFSET_OUT_W{1'b0}}, sel_off};
          if (sel_found) begin
            res_d = '{found: 1'b1, offset: off_ext[OFFSET_OUT_W-1:0],
                      mpeg_id: sel_hdr.mpeg_id, profile: sel_hdr.profile,
                      samp_freq: sel_hdr.samp_freq, channels: sel_hdr.channels,
                      frame_len: sel_hdr.frame_len,
                      crc_present: sel_hdr.crc_present,
                      header_bytes: sel_hdr.header_bytes};
          end else begin
            res_d = '0;
          end
          win_d  = '0;
          fill_d = '0;
          pos_d  = '0;
        end
      end
    end
    out_valid_d = emit || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = res_q.found;
  assign out_o.offset       = res_q.offset;
  assign out_o.mpeg_id      = res_q.mpeg_id;
  assign out_o.profile      = res_q.profile;
  assign out_o.samp_freq    = res_q.samp_freq;
  assign out_o.channels     = res_q.channels;
  assign out_o.frame_len    = res_q.frame_len;
  assign out_o.crc_present  = res_q.crc_present;
  assign out_o.header_bytes = res_q.header_bytes;

  `AACSF_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_fire && in_i.last_byte, !rep_q && (fill_q == '0) && (pos_q == '0), "last byte did not clear the search state")
  `AACSF_ASSERT_SAME(a_rep_full, clk_i, rst_ni, rep_q, fill_q == FILL_FULL, "reported buffer without a full window")
  `AACSF_ASSERT_SAME(a_fill_range, clk_i, rst_ni, !rep_q, fill_q < FILL_FULL, "window fill out of range while searching")
  `AACSF_ASSERT_SAME(a_miss_zero, clk_i, rst_ni, out_o.valid && !out_o.found, (out_o.offset == '0) && (out_o.header_bytes == '0), "not-found result carries nonzero fields")
  `AACSF_ASSERT_SAME(a_hit_size, clk_i, rst_ni, out_o.valid && out_o.found, (out_o.header_bytes >= HB_ID1) && (out_o.header_bytes <= FILL_FULL), "found header has an impossible size")

endmodule
